### rtl/core/iol_pkg.sv
// shared types and constants for the indexed ordered list
package iol_pkg;

  // list geometry
  localparam int CAPACITY   = 64;
  localparam int DATA_WIDTH = 32;
  localparam int IDX_W      = $clog2(CAPACITY);
  localparam int CNT_W      = $clog2(CAPACITY + 1);

  // search tree: cells are reduced in groups, then across groups
  localparam int GROUP_SIZE = 8;
  localparam int SUB_W      = $clog2(GROUP_SIZE);
  localparam int NUM_GROUPS = (CAPACITY + GROUP_SIZE - 1) / GROUP_SIZE;
  localparam int PAD_CELLS  = NUM_GROUPS * GROUP_SIZE;

  // stream field widths
  localparam int CMD_W    = 2;
  localparam int POS_W    = 7;
  localparam int VAL_W    = 32;
  localparam int STAT_W   = 2;
  localparam int FOUND_W  = 6;
  localparam int LEN_W    = 7;
  localparam int IN_BITS  = CMD_W + POS_W + VAL_W;
  localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS = STAT_W + FOUND_W + VAL_W + LEN_W + 1;
  localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_FIND   = 2'd2,
    CMD_READ   = 2'd3
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK       = 2'd0,
    STAT_RANGE    = 2'd1,
    STAT_NOTFOUND = 2'd2,
    STAT_FULL     = 2'd3
  } status_t;

  // operation broadcast to every cell in the same cycle
  typedef enum logic [2:0] {
    OP_NONE,
    OP_INSERT,
    OP_DELETE,
    OP_FIND,
    OP_READ
  } op_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_HIT,
    S_TREE
  } state_t;

  // control word shared by all cells
  typedef struct packed {
    op_t                    op;
    logic [POS_W-1:0]       pos;
    logic [CNT_W-1:0]       count;
    logic [DATA_WIDTH-1:0]  value;
  } ctrl_t;

endpackage

### rtl/core/iol_cell.sv
// one list position: holds a word, shifts with its neighbors, flags search hits
module iol_cell (
  input  logic                          clk,
  input  iol_pkg::ctrl_t                ctrl,
  input  logic [iol_pkg::IDX_W-1:0]     index,
  input  logic [iol_pkg::DATA_WIDTH-1:0] left_data,
  input  logic [iol_pkg::DATA_WIDTH-1:0] right_data,
  output logic [iol_pkg::DATA_WIDTH-1:0] data,
  output logic                          hit,
  output logic [iol_pkg::DATA_WIDTH-1:0] hit_data
);

  logic [iol_pkg::POS_W-1:0]      idx_pos;
  logic [iol_pkg::CNT_W-1:0]      idx_cnt;
  logic                           at_pos;
  logic                           above_pos;
  logic                           in_list;
  logic [iol_pkg::DATA_WIDTH-1:0] data_next;
  logic                           hit_next;

  // position of this cell relative to the command
  assign idx_pos   = iol_pkg::POS_W'(index);
  assign idx_cnt   = iol_pkg::CNT_W'(index);
  assign at_pos    = (idx_pos == ctrl.pos);
  assign above_pos = (idx_pos > ctrl.pos);
  assign in_list   = (idx_cnt < ctrl.count);

  // shift, load and compare
  always_comb begin
    data_next = data;
    hit_next  = 1'b0;
    unique case (ctrl.op)
      iol_pkg::OP_INSERT: begin
        if (at_pos) begin
          data_next = ctrl.value;
        end else if (above_pos) begin
          data_next = left_data;
        end
      end
      iol_pkg::OP_DELETE: begin
        if (at_pos || above_pos) begin
          data_next = right_data;
        end
      end
      iol_pkg::OP_FIND: begin
        hit_next = in_list && (data == ctrl.value);
      end
      iol_pkg::OP_READ: begin
        hit_next = at_pos && in_list;
      end
      default: begin
        hit_next = 1'b0;
      end
    endcase
  end

  // word and hit registers
  always_ff @(posedge clk) begin
    data     <= data_next;
    hit      <= hit_next;
    hit_data <= hit_next ? data : '0;
  end

endmodule

### rtl/core/iol_group.sv
// first stage of the search tree: lowest hit and merged word over one group of cells
module iol_group (
  input  logic                           clk,
  input  logic [iol_pkg::GROUP_SIZE-1:0] hit,
  input  logic [iol_pkg::DATA_WIDTH-1:0] hit_data [iol_pkg::GROUP_SIZE],
  output logic                           any_hit,
  output logic [iol_pkg::SUB_W-1:0]      first,
  output logic [iol_pkg::DATA_WIDTH-1:0] merged
);

  logic [iol_pkg::SUB_W-1:0]      first_next;
  logic [iol_pkg::DATA_WIDTH-1:0] merged_next;

  // lowest set hit, and or of the gated words
  always_comb begin
    first_next  = '0;
    merged_next = '0;
    for (int i = iol_pkg::GROUP_SIZE - 1; i >= 0; i--) begin
      if (hit[i]) begin
        first_next = iol_pkg::SUB_W'(i);
      end
      merged_next = merged_next | hit_data[i];
    end
  end

  always_ff @(posedge clk) begin
    any_hit <= |hit;
    first   <= first_next;
    merged  <= merged_next;
  end

endmodule

### rtl/core/indexed_ordered_list.sv
// top level of the indexed ordered list: command decode, cell chain, search tree, result word
//
// A bounded ordered list of up to 64 words of 32 bits, kept in a row of cells.
// Commands arrive on the s_ group (insert at position, delete at position,
// find value, read position); one result word per command leaves on the m_
// group with status, found position, read value, length and empty flag.
//
// Insert and delete: unless refused, cells at or above the position take a neighbor's
// word or the new word in the same clock edge that accepts the command, so the result
// is valid in the next cycle; one such command can be taken per cycle while results drain.
// Find and read: cells register their hit flags, a group stage reduces each
// eight cells, and the final combine loads the result register; a new command
// waits for that result.
// A find reports the lowest matching position.
//
// A command is taken only while the result register is empty or being drained
// in the same cycle; a stalled receiver holds the result and blocks new
// commands. Reset empties the list and drops any pending result; the cell
// words themselves are not cleared since positions past the length are never
// reported.
module indexed_ordered_list (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  // command[1:0], position[8:2], value[40:9], zero fill[47:41]
  input  logic [iol_pkg::IN_W-1:0]  s_tdata,
  output logic                      m_tvalid,
  input  logic                      m_tready,
  // status[1:0], found_position[7:2], read_value[39:8], list_length[46:40],
  // list_empty[47]
  output logic [iol_pkg::OUT_W-1:0] m_tdata
);

  // input fields
  iol_pkg::cmd_t                  in_cmd;
  logic [iol_pkg::POS_W-1:0]      in_pos;
  logic [iol_pkg::VAL_W-1:0]      in_val;

  assign in_cmd = iol_pkg::cmd_t'(s_tdata[iol_pkg::CMD_W-1:0]);
  assign in_pos = s_tdata[iol_pkg::CMD_W +: iol_pkg::POS_W];
  assign in_val = s_tdata[iol_pkg::CMD_W + iol_pkg::POS_W +: iol_pkg::VAL_W];

  // control state
  iol_pkg::state_t           state, state_next;
  logic [iol_pkg::CNT_W-1:0] count, count_next;
  iol_pkg::cmd_t             pend_cmd;
  logic                      pend_range;

  // result register
  iol_pkg::status_t            out_status;
  logic [iol_pkg::FOUND_W-1:0] out_found;
  logic [iol_pkg::VAL_W-1:0]   out_read;
  logic [iol_pkg::LEN_W-1:0]   out_len;
  logic                        out_empty;

  logic                      out_free;
  logic                      fire;
  logic                      is_update;
  logic                      load_update;
  logic                      load_search;
  iol_pkg::status_t          upd_status;
  iol_pkg::ctrl_t            ctrl;

  assign out_free = !m_tvalid || m_tready;
  assign s_tready = !rst && (state == iol_pkg::S_IDLE) && out_free;
  assign fire     = s_tvalid && s_tready;
  assign is_update = (in_cmd == iol_pkg::CMD_INSERT) || (in_cmd == iol_pkg::CMD_DELETE);
  assign load_update = fire && is_update;
  assign load_search = (state == iol_pkg::S_TREE);

  // range and capacity checks, new length
  always_comb begin
    upd_status = iol_pkg::STAT_OK;
    count_next = count;
    ctrl.op    = iol_pkg::OP_NONE;
    ctrl.pos   = in_pos;
    ctrl.count = count;
    ctrl.value = iol_pkg::DATA_WIDTH'(in_val);
    if (fire) begin
      unique case (in_cmd)
        iol_pkg::CMD_INSERT: begin
          if (in_pos > count) begin
            upd_status = iol_pkg::STAT_RANGE;
          end else if (count == iol_pkg::CNT_W'(iol_pkg::CAPACITY)) begin
            upd_status = iol_pkg::STAT_FULL;
          end else begin
            ctrl.op    = iol_pkg::OP_INSERT;
            count_next = count + iol_pkg::CNT_W'(1);
          end
        end
        iol_pkg::CMD_DELETE: begin
          if (in_pos >= count) begin
            upd_status = iol_pkg::STAT_RANGE;
          end else begin
            ctrl.op    = iol_pkg::OP_DELETE;
            count_next = count - iol_pkg::CNT_W'(1);
          end
        end
        iol_pkg::CMD_FIND: begin
          ctrl.op = iol_pkg::OP_FIND;
        end
        iol_pkg::CMD_READ: begin
          ctrl.op = iol_pkg::OP_READ;
        end
        default: begin
          ctrl.op = iol_pkg::OP_NONE;
        end
      endcase
    end
  end

  // cell chain
  logic [iol_pkg::DATA_WIDTH-1:0] cell_data [iol_pkg::CAPACITY];
  logic [iol_pkg::PAD_CELLS-1:0]  cell_hit;
  logic [iol_pkg::DATA_WIDTH-1:0] cell_hit_data [iol_pkg::PAD_CELLS];

  for (genvar c = 0; c < iol_pkg::CAPACITY; c++) begin : g_cell
    logic [iol_pkg::DATA_WIDTH-1:0] left_word;
    logic [iol_pkg::DATA_WIDTH-1:0] right_word;
    if (c == 0) begin : g_first
      assign left_word = cell_data[c];
    end else begin : g_mid_l
      assign left_word = cell_data[c-1];
    end
    if (c == iol_pkg::CAPACITY - 1) begin : g_last
      assign right_word = cell_data[c];
    end else begin : g_mid_r
      assign right_word = cell_data[c+1];
    end
    iol_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .index      (iol_pkg::IDX_W'(c)),
      .left_data  (left_word),
      .right_data (right_word),
      .data       (cell_data[c]),
      .hit        (cell_hit[c]),
      .hit_data   (cell_hit_data[c])
    );
  end

  // unused tail of the last group never hits
  for (genvar p = iol_pkg::CAPACITY; p < iol_pkg::PAD_CELLS; p++) begin : g_pad
    assign cell_hit[p]      = 1'b0;
    assign cell_hit_data[p] = '0;
  end

  // group stage of the search tree
  logic [iol_pkg::NUM_GROUPS-1:0] grp_any;
  logic [iol_pkg::SUB_W-1:0]      grp_first  [iol_pkg::NUM_GROUPS];
  logic [iol_pkg::DATA_WIDTH-1:0] grp_merged [iol_pkg::NUM_GROUPS];

  for (genvar g = 0; g < iol_pkg::NUM_GROUPS; g++) begin : g_group
    iol_group u_group (
      .clk      (clk),
      .hit      (cell_hit[g*iol_pkg::GROUP_SIZE +: iol_pkg::GROUP_SIZE]),
      .hit_data (cell_hit_data[g*iol_pkg::GROUP_SIZE +: iol_pkg::GROUP_SIZE]),
      .any_hit  (grp_any[g]),
      .first    (grp_first[g]),
      .merged   (grp_merged[g])
    );
  end

  // final combine across groups
  logic [iol_pkg::IDX_W-1:0]      tree_idx;
  logic [iol_pkg::DATA_WIDTH-1:0] tree_data;
  logic                           tree_any;

  always_comb begin
    tree_idx  = '0;
    tree_data = '0;
    tree_any  = |grp_any;
    for (int g = iol_pkg::NUM_GROUPS - 1; g >= 0; g--) begin
      if (grp_any[g]) begin
        tree_idx = iol_pkg::IDX_W'(g * iol_pkg::GROUP_SIZE) + iol_pkg::IDX_W'(grp_first[g]);
      end
      tree_data = tree_data | grp_merged[g];
    end
  end

  // sequencer for find and read
  always_comb begin
    state_next = state;
    unique case (state)
      iol_pkg::S_IDLE: begin
        if (fire && !is_update) begin
          state_next = iol_pkg::S_HIT;
        end
      end
      iol_pkg::S_HIT: begin
        state_next = iol_pkg::S_TREE;
      end
      iol_pkg::S_TREE: begin
        state_next = iol_pkg::S_IDLE;
      end
      default: begin
        state_next = iol_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= iol_pkg::S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  // pending search command
  always_ff @(posedge clk) begin
    if (fire) begin
      pend_cmd   <= in_cmd;
      pend_range <= (in_pos >= count);
    end
  end

  // result valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_update || load_search) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // result word
  always_ff @(posedge clk) begin
    if (load_update) begin
      out_status <= upd_status;
      out_found  <= '0;
      out_read   <= '0;
      out_len    <= iol_pkg::LEN_W'(count_next);
      out_empty  <= (count_next == '0);
    end else if (load_search) begin
      out_len   <= iol_pkg::LEN_W'(count);
      out_empty <= (count == '0);
      if (pend_cmd == iol_pkg::CMD_FIND) begin
        out_status <= tree_any ? iol_pkg::STAT_OK : iol_pkg::STAT_NOTFOUND;
        out_found  <= tree_any ? iol_pkg::FOUND_W'(tree_idx) : '0;
        out_read   <= '0;
      end else begin
        out_status <= pend_range ? iol_pkg::STAT_RANGE : iol_pkg::STAT_OK;
        out_found  <= '0;
        out_read   <= iol_pkg::VAL_W'(tree_data);
      end
    end
  end

  assign m_tdata = iol_pkg::OUT_W'({
    out_empty,
    out_len,
    out_read,
    out_found,
    out_status
  });

  // length never passes the capacity
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= iol_pkg::CNT_W'(iol_pkg::CAPACITY))
    else $error("list length above capacity");

  // insert into a full list leaves the length unchanged
  a_full_insert: assert property (@(posedge clk) disable iff (rst)
    (fire && in_cmd == iol_pkg::CMD_INSERT && in_pos <= count &&
     count == iol_pkg::CNT_W'(iol_pkg::CAPACITY)) |=> $stable(count))
    else $error("insert into full list changed the length");

  // no command is taken while a search walks the tree
  a_busy_block: assert property (@(posedge clk) disable iff (rst)
    (state != iol_pkg::S_IDLE) |-> !s_tready)
    else $error("command accepted during search");

  // a find or read passes through the hit and tree states, then returns its result
  a_search_latency: assert property (@(posedge clk) disable iff (rst)
    (fire && !is_update) |=> ##1 (state == iol_pkg::S_TREE) ##1 m_tvalid)
    else $error("search result not produced on time");

endmodule
